[design/tlc_pkg.sv]
// Shared types, constants and the cost function of the three-level cache controller.
package tlc_pkg;

    typedef logic [1:0] t_lvl;

    localparam t_lvl LVL_L1 = 2'd1;
    localparam t_lvl LVL_L2 = 2'd2;
    localparam t_lvl LVL_L3 = 2'd3;

    localparam logic [2:0] HIT_L1  = 3'd1;
    localparam logic [2:0] HIT_L2  = 3'd2;
    localparam logic [2:0] HIT_L3  = 3'd3;
    localparam logic [2:0] HIT_RAM = 3'd4;

    localparam logic KIND_WB  = 1'b0;
    localparam logic KIND_FIN = 1'b1;

    localparam logic [10:0] COST_L1  = 11'd10;
    localparam logic [10:0] COST_L2  = 11'd50;
    localparam logic [10:0] COST_L3  = 11'd100;
    localparam logic [10:0] COST_RAM = 11'd1000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PMOD,
        S_PWAIT,
        S_P1RD,
        S_P1CHK,
        S_P2RD,
        S_P2CHK,
        S_P3RD,
        S_P3CHK,
        S_PLACE,
        S_IMOD,
        S_IWAIT,
        S_IRD,
        S_ICHK,
        S_IEMIT,
        S_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       cap_in;
        logic       mod_start;
        logic       mod_ln;
        logic       rd;
        logic       wr_probe;
        logic       wr_ins;
        t_lvl       lvl;
        logic       use_ln;
        logic       chk;
        logic       got_new;
        logic       ln_ld;
        logic       ln_l1;
        logic       ln_vic;
        logic       hit_ld;
        logic [2:0] hit_val;
        logic       emit_wb;
        logic       emit_fin;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mod_busy;
        logic hit;
        logic vic_wb;
        logic out_free;
    } t_dp_sts;

    function automatic logic [10:0] f_cost(input logic [2:0] hit);
        logic [10:0] c;
        c = COST_L1;
        unique case (hit)
            HIT_L2:  c = COST_L1 + COST_L2;
            HIT_L3:  c = COST_L1 + COST_L2 + COST_L3;
            HIT_RAM: c = COST_L1 + COST_L2 + COST_L3 + COST_RAM;
            default: c = COST_L1;
        endcase
        return c;
    endfunction

endpackage

[design/tlc_if.sv]
// Valid/ready channel interfaces for accesses and result records.
interface tlc_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] block_addr;

    modport source(output valid, output op, output block_addr, input ready);
    modport sink(input valid, input op, input block_addr, output ready);
endinterface

interface tlc_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  from_level;
    logic [15:0] wb_addr;
    logic [2:0]  hit_level;
    logic [10:0] cost;
    logic        last;

    modport source(output valid, output kind, output from_level, output wb_addr,
                   output hit_level, output cost, output last, input ready);
    modport sink(input valid, input kind, input from_level, input wb_addr,
                 input hit_level, input cost, input last, output ready);
endinterface

[design/tlc_setmod.sv]
// Set index unit: remainder of a block address by the set count through a reciprocal multiply.
module tlc_setmod #(
    parameter int ADDR_BITS = 16,
    parameter int SETS      = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [ADDR_BITS-1:0] i_value,
    output logic                 o_busy,
    output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] o_rem
);
    localparam int IW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int LG = $clog2(SETS);
    localparam int SH = ADDR_BITS + LG;
    localparam int MW = ADDR_BITS + 1;
    localparam int PW = 2 * ADDR_BITS + 1;
    // Rounded-up reciprocal; with this shift the quotient is exact for every address.
    localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(SETS) - 64'd1) / 64'(SETS);
    localparam logic [ADDR_BITS-1:0] DIVC = ADDR_BITS'(SETS);

    logic [ADDR_BITS-1:0] r_val;
    logic [1:0]           r_cnt;
    logic [PW-1:0]        r_prod;
    logic [IW-1:0]        r_rem;
    logic [ADDR_BITS-1:0] quo;
    logic [ADDR_BITS-1:0] rem_full;

    always_comb begin
        quo      = ADDR_BITS'(r_prod >> SH);
        rem_full = r_val - quo * DIVC;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 2'd2;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // The first step forms the product, the second the remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
        end
        if (r_cnt == 2'd2) begin
            r_prod <= {{MW{1'b0}}, r_val} * {{ADDR_BITS{1'b0}}, RECIP[MW-1:0]};
        end
        if (r_cnt == 2'd1) begin
            r_rem <= IW'(rem_full);
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_rem;
endmodule

[design/tlc_store.sv]
// Tag store of one cache level: one row of two ways per set, valid bits in flops.
module tlc_store #(
    parameter int SETS = 8,
    parameter int W    = 66
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd,
    input  logic                 i_wr,
    input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] i_idx,
    input  logic [W-1:0]         i_wrow,
    input  logic [1:0]           i_wvld,
    output logic [W-1:0]         o_rrow,
    output logic [1:0]           o_rvld
);
    logic [W-1:0]    mem [SETS];
    logic [SETS-1:0] r_v0;
    logic [SETS-1:0] r_v1;
    logic [W-1:0]    r_rrow;
    logic [1:0]      r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem[i_idx] <= i_wrow;
        end
        if (i_rd) begin
            r_rrow <= mem[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= '0;
            r_v1   <= '0;
            r_rvld <= '0;
        end else begin
            if (i_wr) begin
                r_v0[i_idx] <= i_wvld[0];
                r_v1[i_idx] <= i_wvld[1];
            end
            if (i_rd) begin
                r_rvld <= {r_v1[i_idx], r_v0[i_idx]};
            end
        end
    end

    assign o_rrow = r_rrow;
    assign o_rvld = r_rvld;
endmodule

[design/tlc_dpath.sv]
// Datapath: set index units, three tag stores, line registers and output register.
module tlc_dpath import tlc_pkg::*; #(
    parameter int L1_LINES   = 16,
    parameter int L2_LINES   = 64,
    parameter int L3_LINES   = 256,
    parameter int ADDR_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic        i_op,
    input  logic [15:0] i_block_addr,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic        o_kind,
    output logic [1:0]  o_from_level,
    output logic [15:0] o_wb_addr,
    output logic [2:0]  o_hit_level,
    output logic [10:0] o_cost,
    output logic        o_last
);
    localparam int S1  = L1_LINES / 2;
    localparam int S2  = L2_LINES / 2;
    localparam int S3  = L3_LINES / 2;
    localparam int IW1 = (S1 > 1) ? $clog2(S1) : 1;
    localparam int IW2 = (S2 > 1) ? $clog2(S2) : 1;
    localparam int IW3 = (S3 > 1) ? $clog2(S3) : 1;
    localparam int AB  = ADDR_BITS;
    localparam int CB  = COUNT_BITS;
    localparam int WW  = 1 + AB + CB;
    localparam int RW  = 2 * WW;

    logic [AB-1:0]  r_addr;
    logic           r_wr;
    logic           r_got_d;
    logic [AB-1:0]  r_got_tag;
    logic [CB-1:0]  r_got_cnt;
    logic           r_ln_d;
    logic [AB-1:0]  r_ln_tag;
    logic [CB-1:0]  r_ln_cnt;
    logic [AB-1:0]  r_vic_tag;
    logic [CB-1:0]  r_vic_cnt;
    logic [2:0]     r_hit;

    logic           r_ov;
    logic           r_kind;
    logic [1:0]     r_from;
    logic [15:0]    r_wba;
    logic [2:0]     r_hl;
    logic [10:0]    r_cost;

    logic [AB-1:0]  mod_val;
    logic           busy1, busy2, busy3;
    logic [IW1-1:0] idx1;
    logic [IW2-1:0] idx2;
    logic [IW3-1:0] idx3;

    logic [RW-1:0]  row1, row2, row3, row;
    logic [1:0]     v1, v2, v3, v;
    logic           wr_any;
    logic [RW-1:0]  n_row;
    logic [1:0]     n_vld;

    logic [1:0]     w_d;
    logic [AB-1:0]  w_tag [2];
    logic [CB-1:0]  w_cnt [2];
    logic [AB-1:0]  tgt;
    logic [1:0]     w_hit;
    logic           hit;
    logic           hit_way;
    logic           vic_way;
    logic           slot;
    logic           ins_hit;
    logic [CB-1:0]  inc_cnt;
    logic           upd_d;
    logic           vic_wb;

    assign mod_val = i_cmd.mod_ln ? r_ln_tag : r_addr;

    tlc_setmod #(.ADDR_BITS(AB), .SETS(S1)) u_mod1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.mod_start),
        .i_value(mod_val), .o_busy(busy1), .o_rem(idx1));
    tlc_setmod #(.ADDR_BITS(AB), .SETS(S2)) u_mod2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.mod_start),
        .i_value(mod_val), .o_busy(busy2), .o_rem(idx2));
    tlc_setmod #(.ADDR_BITS(AB), .SETS(S3)) u_mod3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.mod_start),
        .i_value(mod_val), .o_busy(busy3), .o_rem(idx3));

    assign wr_any = i_cmd.wr_probe | i_cmd.wr_ins;

    tlc_store #(.SETS(S1), .W(RW)) u_st1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_rd(i_cmd.rd && i_cmd.lvl == LVL_L1), .i_wr(wr_any && i_cmd.lvl == LVL_L1),
        .i_idx(idx1), .i_wrow(n_row), .i_wvld(n_vld), .o_rrow(row1), .o_rvld(v1));
    tlc_store #(.SETS(S2), .W(RW)) u_st2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_rd(i_cmd.rd && i_cmd.lvl == LVL_L2), .i_wr(wr_any && i_cmd.lvl == LVL_L2),
        .i_idx(idx2), .i_wrow(n_row), .i_wvld(n_vld), .o_rrow(row2), .o_rvld(v2));
    tlc_store #(.SETS(S3), .W(RW)) u_st3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_rd(i_cmd.rd && i_cmd.lvl == LVL_L3), .i_wr(wr_any && i_cmd.lvl == LVL_L3),
        .i_idx(idx3), .i_wrow(n_row), .i_wvld(n_vld), .o_rrow(row3), .o_rvld(v3));

    always_comb begin
        unique case (i_cmd.lvl)
            LVL_L1: begin
                row = row1;
                v   = v1;
            end
            LVL_L2: begin
                row = row2;
                v   = v2;
            end
            default: begin
                row = row3;
                v   = v3;
            end
        endcase
    end

    // Way decode, tag match and LFU victim choice on the row just read.
    always_comb begin
        for (int w = 0; w < 2; w++) begin
            w_d[w]   = row[w*WW + AB + CB];
            w_tag[w] = row[w*WW + CB +: AB];
            w_cnt[w] = row[w*WW +: CB];
        end
        tgt   = i_cmd.use_ln ? r_ln_tag : r_addr;
        w_hit = {v[1] && (w_tag[1] == tgt), v[0] && (w_tag[0] == tgt)};
        hit     = |w_hit;
        hit_way = !w_hit[0];
        if (!v[0]) begin
            vic_way = 1'b0;
        end else if (!v[1]) begin
            vic_way = 1'b1;
        end else begin
            vic_way = (w_cnt[1] < w_cnt[0]);
        end
        ins_hit = i_cmd.chk && hit;
        slot    = ins_hit ? hit_way : vic_way;
        vic_wb  = !ins_hit && v[slot] && w_d[slot];
        inc_cnt = (w_cnt[hit_way] == {CB{1'b1}}) ? w_cnt[hit_way]
                                                 : w_cnt[hit_way] + 1'b1;
        upd_d   = w_d[hit_way] | ((i_cmd.lvl == LVL_L1) & r_wr);
        n_row = row;
        n_vld = v;
        if (i_cmd.wr_ins) begin
            n_row[slot*WW +: WW] = {r_ln_d, r_ln_tag, r_ln_cnt};
            n_vld[slot]          = 1'b1;
        end else begin
            n_row[hit_way*WW +: WW] = {upd_d, w_tag[hit_way], inc_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_addr <= AB'(i_block_addr);
            r_wr   <= i_op;
        end
        if (i_cmd.wr_probe) begin
            r_got_d   <= upd_d;
            r_got_tag <= w_tag[hit_way];
            r_got_cnt <= inc_cnt;
        end else if (i_cmd.got_new) begin
            r_got_d   <= 1'b0;
            r_got_tag <= r_addr;
            r_got_cnt <= '0;
        end
        if (i_cmd.ln_ld) begin
            r_ln_d   <= r_got_d | (i_cmd.ln_l1 & r_wr);
            r_ln_tag <= r_got_tag;
            r_ln_cnt <= (i_cmd.ln_l1 && r_hit == HIT_RAM) ? CB'(1) : r_got_cnt;
        end else if (i_cmd.ln_vic) begin
            r_ln_d   <= 1'b1;
            r_ln_tag <= r_vic_tag;
            r_ln_cnt <= r_vic_cnt;
        end
        if (i_cmd.wr_ins) begin
            r_vic_tag <= w_tag[slot];
            r_vic_cnt <= w_cnt[slot];
        end
        if (i_cmd.hit_ld) begin
            r_hit <= i_cmd.hit_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit_wb || i_cmd.emit_fin) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_wb) begin
            r_kind <= KIND_WB;
            r_from <= i_cmd.lvl;
            r_wba  <= 16'(r_vic_tag);
            r_hl   <= '0;
            r_cost <= '0;
        end else if (i_cmd.emit_fin) begin
            r_kind <= KIND_FIN;
            r_from <= '0;
            r_wba  <= '0;
            r_hl   <= r_hit;
            r_cost <= f_cost(r_hit);
        end
    end

    assign o_sts.mod_busy = busy1 | busy2 | busy3;
    assign o_sts.hit      = hit;
    assign o_sts.vic_wb   = vic_wb;
    assign o_sts.out_free = !r_ov || i_out_ready;

    assign o_out_valid  = r_ov;
    assign o_kind       = r_kind;
    assign o_from_level = r_from;
    assign o_wb_addr    = r_wba;
    assign o_hit_level  = r_hl;
    assign o_cost       = r_cost;
    assign o_last       = r_kind;
endmodule

[design/tlc_ctrl.sv]
// Controller: sequences probes, line placement and write-back cascades.
module tlc_ctrl import tlc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    t_state r_state, n_state;
    t_lvl   r_lvl;
    t_lvl   r_base;
    logic   r_chk;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_PMOD;
            S_PMOD:  n_state = S_PWAIT;
            S_PWAIT: if (!i_sts.mod_busy) n_state = S_P1RD;
            S_P1RD:  n_state = S_P1CHK;
            S_P1CHK: n_state = i_sts.hit ? S_FIN : S_P2RD;
            S_P2RD:  n_state = S_P2CHK;
            S_P2CHK: n_state = i_sts.hit ? S_PLACE : S_P3RD;
            S_P3RD:  n_state = S_P3CHK;
            S_P3CHK: n_state = S_PLACE;
            S_PLACE: n_state = S_IMOD;
            S_IMOD:  n_state = S_IWAIT;
            S_IWAIT: if (!i_sts.mod_busy) n_state = S_IRD;
            S_IRD:   n_state = S_ICHK;
            S_ICHK: begin
                priority if (i_sts.vic_wb) n_state = S_IEMIT;
                else if (r_base == LVL_L1) n_state = S_FIN;
                else n_state = S_PLACE;
            end
            S_IEMIT: begin
                if (i_sts.out_free) begin
                    priority if (r_lvl != LVL_L3) n_state = S_IMOD;
                    else if (r_base == LVL_L1) n_state = S_FIN;
                    else n_state = S_PLACE;
                end
            end
            S_FIN:   if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.cap_in = i_in_valid;
            end
            S_PMOD:  o_cmd.mod_start = 1'b1;
            S_P1RD: begin
                o_cmd.rd  = 1'b1;
                o_cmd.lvl = LVL_L1;
            end
            S_P1CHK: begin
                o_cmd.lvl      = LVL_L1;
                o_cmd.wr_probe = i_sts.hit;
                o_cmd.hit_ld   = i_sts.hit;
                o_cmd.hit_val  = HIT_L1;
            end
            S_P2RD: begin
                o_cmd.rd  = 1'b1;
                o_cmd.lvl = LVL_L2;
            end
            S_P2CHK: begin
                o_cmd.lvl      = LVL_L2;
                o_cmd.wr_probe = i_sts.hit;
                o_cmd.hit_ld   = i_sts.hit;
                o_cmd.hit_val  = HIT_L2;
            end
            S_P3RD: begin
                o_cmd.rd  = 1'b1;
                o_cmd.lvl = LVL_L3;
            end
            S_P3CHK: begin
                o_cmd.lvl      = LVL_L3;
                o_cmd.wr_probe = i_sts.hit;
                o_cmd.got_new  = !i_sts.hit;
                o_cmd.hit_ld   = 1'b1;
                o_cmd.hit_val  = i_sts.hit ? HIT_L3 : HIT_RAM;
            end
            S_PLACE: begin
                o_cmd.ln_ld = 1'b1;
                o_cmd.ln_l1 = (r_base == LVL_L1);
            end
            S_IMOD: begin
                o_cmd.mod_start = 1'b1;
                o_cmd.mod_ln    = 1'b1;
            end
            S_IRD: begin
                o_cmd.rd  = 1'b1;
                o_cmd.lvl = r_lvl;
            end
            S_ICHK: begin
                o_cmd.wr_ins = 1'b1;
                o_cmd.lvl    = r_lvl;
                o_cmd.use_ln = 1'b1;
                o_cmd.chk    = r_chk;
            end
            S_IEMIT: begin
                o_cmd.lvl     = r_lvl;
                o_cmd.emit_wb = i_sts.out_free;
                o_cmd.ln_vic  = i_sts.out_free && (r_lvl != LVL_L3);
            end
            S_FIN:   o_cmd.emit_fin = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lvl   <= LVL_L1;
            r_base  <= LVL_L1;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_P2CHK && i_sts.hit) begin
                r_base <= LVL_L1;
            end else if (r_state == S_P3CHK) begin
                r_base <= i_sts.hit ? LVL_L2 : LVL_L3;
            end else if (r_state == S_PLACE) begin
                r_lvl <= r_base;
                r_chk <= 1'b0;
            end else if (n_state == S_PLACE) begin
                // A placement chain has ended; the next one goes one level up.
                r_base <= r_base - 1'b1;
            end else if (r_state == S_IEMIT && n_state == S_IMOD) begin
                r_lvl <= r_lvl + 1'b1;
                r_chk <= 1'b1;
            end
        end
    end
endmodule

[design/three_level_lfu_cache_controller_unit.sv]
// Top level of the three-level LFU write-back cache tag controller.
//
// i_acc carries one access (op, block_addr) per transaction; the block takes
// a new access only after the previous one has issued its final record.
// o_res returns, per access, zero or more write-back records (kind 0) in
// eviction order, then one final record (kind 1, last 1) with hit level
// and cost. Each record sits in an output register until o_res.ready.
// Each access's probe and each line placement first run the set-index units,
// then registered tag-store reads; a placement and a probe hit also write.
// Reset clears all valid bits at once, so the block is usable as soon as
// reset is released. A stalled receiver holds the sequencer at the next
// record; no record is dropped or repeated.
module three_level_lfu_cache_controller_unit import tlc_pkg::*; #(
    parameter int L1_LINES   = 16,
    parameter int L2_LINES   = 64,
    parameter int L3_LINES   = 256,
    parameter int ADDR_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlc_in_if.sink     i_acc,
    tlc_out_if.source  o_res
);
    t_dp_cmd cmd;
    t_dp_sts sts;

    tlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_acc.valid),
        .o_in_ready (i_acc.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tlc_dpath #(
        .L1_LINES   (L1_LINES),
        .L2_LINES   (L2_LINES),
        .L3_LINES   (L3_LINES),
        .ADDR_BITS  (ADDR_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (i_acc.op),
        .i_block_addr (i_acc.block_addr),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_kind       (o_res.kind),
        .o_from_level (o_res.from_level),
        .o_wb_addr    (o_res.wb_addr),
        .o_hit_level  (o_res.hit_level),
        .o_cost       (o_res.cost),
        .o_last       (o_res.last)
    );
endmodule

[sim/tb_three_level_lfu_cache_controller_unit.sv]
// Self-checking testbench of the three-level LFU cache controller with a built-in cache predictor.
module tb_three_level_lfu_cache_controller_unit import tlc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N1 = 16;
    localparam int N2 = 64;
    localparam int N3 = 256;
    localparam int CMAX = 65535;

    typedef struct {
        bit          v;
        bit          d;
        logic [15:0] tag;
        int unsigned cnt;
    } t_line;

    typedef struct {
        logic        kind;
        logic [1:0]  from_level;
        logic [15:0] wb_addr;
        logic [2:0]  hit_level;
        logic [10:0] cost;
        logic        last;
    } t_rec;

    typedef struct {
        logic        op;
        logic [15:0] addr;
    } t_acc;

    logic i_clk;
    logic i_rst_n;
    tlc_in_if  acc_ch();
    tlc_out_if res_ch();

    three_level_lfu_cache_controller_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_acc(acc_ch.sink), .o_res(res_ch.source)
    );

    t_line l1 [N1];
    t_line l2 [N2];
    t_line l3 [N3];
    t_rec  exp_recs[$];
    t_acc  pending[$];
    int    errors = 0;
    bit    hold_sink = 0;
    bit    pause_src = 0;
    bit    stim_done = 0;

    function automatic int sets_of(int lvl);
        return lvl == 1 ? N1 / 2 : (lvl == 2 ? N2 / 2 : N3 / 2);
    endfunction

    function automatic t_line get_ln(int lvl, int idx);
        return lvl == 1 ? l1[idx] : (lvl == 2 ? l2[idx] : l3[idx]);
    endfunction

    function automatic void put_ln(int lvl, int idx, t_line ln);
        if (lvl == 1) l1[idx] = ln;
        else if (lvl == 2) l2[idx] = ln;
        else l3[idx] = ln;
    endfunction

    function automatic int lookup(int lvl, logic [15:0] a);
        int b;
        t_line ln;
        b = (a % sets_of(lvl)) * 2;
        for (int w = 0; w < 2; w++) begin
            ln = get_ln(lvl, b + w);
            if (ln.v && ln.tag == a) return b + w;
        end
        return -1;
    endfunction

    function automatic int victim(int lvl, logic [15:0] a);
        int b;
        t_line l0, lw;
        b = (a % sets_of(lvl)) * 2;
        l0 = get_ln(lvl, b);
        lw = get_ln(lvl, b + 1);
        if (!l0.v) return b;
        if (!lw.v) return b + 1;
        return (lw.cnt < l0.cnt) ? b + 1 : b;
    endfunction

    function automatic void push_wb(int lvl, logic [15:0] a);
        t_rec r;
        r.kind = KIND_WB; r.from_level = t_lvl'(lvl); r.wb_addr = a;
        r.hit_level = 0; r.cost = 0; r.last = 0;
        exp_recs.push_back(r);
    endfunction

    function automatic void evict(int lvl, t_line ln);
        int idx;
        if (!(ln.v && ln.d)) return;
        push_wb(lvl, ln.tag);
        if (lvl >= 3) return;
        idx = lookup(lvl + 1, ln.tag);
        if (idx < 0) begin
            idx = victim(lvl + 1, ln.tag);
            evict(lvl + 1, get_ln(lvl + 1, idx));
        end
        ln.d = 1;
        put_ln(lvl + 1, idx, ln);
    endfunction

    function automatic void install(int lvl, logic [15:0] a, t_line ln);
        int idx;
        idx = victim(lvl, a);
        evict(lvl, get_ln(lvl, idx));
        put_ln(lvl, idx, ln);
    endfunction

    function automatic int unsigned bump(int unsigned c);
        return c < CMAX ? c + 1 : CMAX;
    endfunction

    function automatic void predict_access(logic op, logic [15:0] a);
        int w;
        t_line got;
        logic [2:0] hl;
        t_rec r;
        w = lookup(1, a);
        if (w >= 0) begin
            l1[w].cnt = bump(l1[w].cnt);
            if (op) l1[w].d = 1;
            hl = HIT_L1;
        end else begin
            w = lookup(2, a);
            if (w >= 0) begin
                l2[w].cnt = bump(l2[w].cnt);
                got = l2[w];
                hl = HIT_L2;
            end else begin
                w = lookup(3, a);
                if (w >= 0) begin
                    l3[w].cnt = bump(l3[w].cnt);
                    got = l3[w];
                    hl = HIT_L3;
                    install(2, a, got);
                end else begin
                    got.v = 1; got.d = 0; got.tag = a; got.cnt = 0;
                    hl = HIT_RAM;
                    install(3, a, got);
                    install(2, a, got);
                    got.cnt = 1;
                end
            end
            w = victim(1, a);
            evict(1, l1[w]);
            if (op) got.d = 1;
            l1[w] = got;
        end
        r.kind = KIND_FIN; r.from_level = 0; r.wb_addr = 0;
        r.hit_level = hl;
        r.cost = hl == HIT_L1 ? COST_L1 : hl == HIT_L2 ? COST_L1 + COST_L2 :
                 hl == HIT_L3 ? COST_L1 + COST_L2 + COST_L3 :
                 COST_L1 + COST_L2 + COST_L3 + COST_RAM;
        r.last = 1;
        exp_recs.push_back(r);
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: bursts of transactions with random gaps.
    int burst_left = 0;
    int gap_left = 0;
    initial begin
        acc_ch.valid = 0; acc_ch.op = 0; acc_ch.block_addr = 0;
    end
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            acc_ch.valid <= 0;
        end else begin
            automatic bit taken = acc_ch.valid && acc_ch.ready;
            automatic bit busy = acc_ch.valid && !taken;
            if (taken) predict_access(acc_ch.op, acc_ch.block_addr);
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    acc_ch.valid <= 0;
                end else if (pending.size() > 0 && !pause_src) begin
                    automatic t_acc it = pending.pop_front();
                    acc_ch.valid <= 1;
                    acc_ch.op <= it.op;
                    acc_ch.block_addr <= it.addr;
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end else begin
                    acc_ch.valid <= 0;
                end
            end
        end
    end

    // Monitor and receiver stall pattern.
    int stall_phase = 0;
    initial res_ch.ready = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (exp_recs.size() == 0) report_mismatch("unexpected record");
                else begin
                    automatic t_rec e = exp_recs.pop_front();
                    if (res_ch.kind !== e.kind) report_mismatch("kind");
                    if (res_ch.from_level !== e.from_level) report_mismatch("from_level");
                    if (res_ch.wb_addr !== e.wb_addr)
                        report_mismatch($sformatf("wb_addr %h exp %h",
                                                  res_ch.wb_addr, e.wb_addr));
                    if (res_ch.hit_level !== e.hit_level)
                        report_mismatch($sformatf("hit_level %0d exp %0d",
                                                  res_ch.hit_level, e.hit_level));
                    if (res_ch.cost !== e.cost) report_mismatch("cost");
                    if (res_ch.last !== e.last) report_mismatch("last");
                end
            end
            stall_phase = (stall_phase + 1) % 97;
            if (hold_sink) res_ch.ready <= 0;
            else if (stall_phase < 40) res_ch.ready <= 1;
            else res_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    function automatic logic [15:0] rand_addr(int mode);
        // Most addresses come from a small pool so sets collide and lines get reused.
        case (mode)
            0: return 16'($urandom_range(0, 3) * 128 + $urandom_range(0, 3));
            1: return 16'($urandom_range(0, 1023));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add(logic op, logic [15:0] a);
        t_acc it;
        it.op = op; it.addr = a;
        pending.push_back(it);
    endtask

    initial begin
        int n;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        // Directed: extremes, every hit level, dirty cascades down to RAM.
        add(0, 16'h0000); add(0, 16'h0000); add(1, 16'hFFFF); add(0, 16'hFFFF);
        for (int k = 0; k < 6; k++) add(1, 16'(k * 8));
        add(0, 16'h0000); add(0, 16'h0008);
        for (int k = 0; k < 6; k++) add(1, 16'(k * 128 + 8));
        add(0, 16'h0010); add(1, 16'h0000); add(0, 16'hAAAA); add(1, 16'h5555);
        add(0, 16'h8000);
        // Long receiver hold-off while the sender keeps offering.
        for (int k = 0; k < 20; k++) add($urandom_range(0, 1), rand_addr(0));
        hold_sink = 1;
        repeat (400) @(posedge i_clk);
        hold_sink = 0;
        wait (pending.size() == 0);
        // Sender pause until everything is back.
        pause_src = 1;
        wait (!acc_ch.valid && exp_recs.size() == 0);
        repeat (200) @(posedge i_clk);
        pause_src = 0;
        n = 0;
        while (n < 380) begin
            automatic int m = $urandom_range(0, 9);
            add($urandom_range(0, 1), rand_addr(m < 6 ? 0 : (m < 9 ? 1 : 2)));
            n++;
        end
        // A short hot loop on one address to push the counters up.
        for (int k = 0; k < 30; k++) add($urandom_range(0, 1), 16'h0003);
        wait (pending.size() == 0 && !acc_ch.valid);
        wait (exp_recs.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && exp_recs.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

[sim.f]
design/tlc_pkg.sv
design/tlc_if.sv
design/tlc_setmod.sv
design/tlc_store.sv
design/tlc_dpath.sv
design/tlc_ctrl.sv
design/three_level_lfu_cache_controller_unit.sv
sim/tb_three_level_lfu_cache_controller_unit.sv
